FILE: sv/mlfs_pkg.sv
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared constants, codes and types of the marker/length frame splitter.
// ----------------------------------------------------------------------------
package mlfs_pkg;

	localparam int unsigned DataW   = 8;
	localparam int unsigned LenW    = 15;
	localparam int unsigned HdrLenW = 16;

	localparam logic [DataW-1:0] StartMarker  = 8'h80;
	localparam logic [LenW-1:0]  MinLength    = 15'd3;
	localparam logic [LenW-1:0]  MaxLenReset  = 15'd1024;

	// result kind
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_ERROR   = 1'b1;

	// error codes
	localparam logic ERR_BAD_MARKER = 1'b0;
	localparam logic ERR_LENGTH     = 1'b1;

	typedef struct packed {
		logic             kind;
		logic             error_code;
		logic [DataW-1:0] payload_byte;
		logic [LenW-1:0]  frame_length;
		logic             last_byte;
	} result_t;

	// handoff from input register to parser
	typedef struct packed {
		logic             fire;
		logic [DataW-1:0] data;
	} step_t;

endpackage

FILE: sv/mlfs_ifs.sv
// ----------------------------------------------------------------------------
// mlfs interfaces
// Valid/ready channels for received bytes and for result words.
// ----------------------------------------------------------------------------
interface mlfs_byte_if;
	import mlfs_pkg::*;

	logic             valid;
	logic             ready;
	logic [DataW-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface mlfs_result_if;
	import mlfs_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic             error_code;
	logic [DataW-1:0] payload_byte;
	logic [LenW-1:0]  frame_length;
	logic             last_byte;

	modport source (output valid, output kind, output error_code, output payload_byte,
		output frame_length, output last_byte, input ready);
	modport sink   (input valid, input kind, input error_code, input payload_byte,
		input frame_length, input last_byte, output ready);
endinterface

FILE: sv/mlfs_in_reg.sv
// ----------------------------------------------------------------------------
// mlfs_in_reg
// Input register: capture one byte word, release it when the result side moves.
// ----------------------------------------------------------------------------
module mlfs_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	mlfs_byte_if.sink      byte_in,
	input  logic           can_take,
	output mlfs_pkg::step_t step
);
	import mlfs_pkg::*;

	logic             valid_s1;
	logic [DataW-1:0] data_s1;
	logic             accept;

	assign byte_in.ready = !valid_s1 || can_take;
	assign accept        = byte_in.valid && byte_in.ready;
	assign step.fire     = valid_s1 && can_take;
	assign step.data     = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (can_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= byte_in.data_byte;
		end
	end

endmodule

FILE: sv/mlfs_parse.sv
// ----------------------------------------------------------------------------
// mlfs_parse
// Frame state machine: hunt marker, take length, check it, pass payload.
// ----------------------------------------------------------------------------
module mlfs_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mlfs_pkg::LenW-1:0] cfg_data,
	input  mlfs_pkg::step_t           step,
	output logic                      res_valid,
	output mlfs_pkg::result_t         res
);
	import mlfs_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_LEN_LO  = 2'd1,
		PH_LEN_HI  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [DataW-1:0]   len_lo_q, len_lo_d;
	logic [HdrLenW-1:0] cur_len_q, cur_len_d;
	logic [LenW-1:0]    remaining_q, remaining_d;
	logic [LenW-1:0]    max_len_q;
	logic [LenW-1:0]    rem_base;
	logic [LenW-1:0]    rem_next;
	logic               len_bad;

	// signed length: negative, too short or above the limit
	assign len_bad = cur_len_q[HdrLenW-1] || (cur_len_q[LenW-1:0] < MinLength) ||
		(cur_len_q[LenW-1:0] > max_len_q);
	assign rem_base = (remaining_q == '0) ? cur_len_q[LenW-1:0] : remaining_q;
	assign rem_next = rem_base - LenW'(1);

	always_comb begin
		phase_d     = phase_q;
		len_lo_d    = len_lo_q;
		cur_len_d   = cur_len_q;
		remaining_d = remaining_q;
		res_valid   = 1'b0;
		res         = '0;
		case (phase_q)
			PH_HUNT: begin
				if (step.data != StartMarker) begin
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_BAD_MARKER;
				end else begin
					phase_d = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				len_lo_d = step.data;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				cur_len_d   = {step.data, len_lo_q};
				remaining_d = '0;
				phase_d     = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				if ((remaining_q == '0) && len_bad) begin
					res.kind       = KIND_ERROR;
					res.error_code = ERR_LENGTH;
					remaining_d    = '0;
					phase_d        = PH_HUNT;
				end else begin
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = step.data;
					res.frame_length = cur_len_q[LenW-1:0];
					res.last_byte    = (rem_next == '0);
					remaining_d      = rem_next;
					if (rem_next == '0) begin
						phase_d = PH_HUNT;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			len_lo_q    <= '0;
			cur_len_q   <= '0;
			remaining_q <= '0;
			max_len_q   <= MaxLenReset;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			if (step.fire) begin
				phase_q     <= phase_d;
				len_lo_q    <= len_lo_d;
				cur_len_q   <= cur_len_d;
				remaining_q <= remaining_d;
			end
		end
	end

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(remaining_q != '0) |-> (remaining_q < cur_len_q[LenW-1:0]))
		else $error("remaining count not below frame length");

	a_last_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(step.fire && res_valid && (res.kind == KIND_PAYLOAD) && res.last_byte)
		|=> (phase_q == PH_HUNT))
		else $error("last payload word did not return to hunt");

	a_payload_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		(step.fire && res_valid && (res.kind == KIND_PAYLOAD))
		|-> (res.frame_length >= MinLength))
		else $error("payload passed with short frame length");

endmodule

FILE: sv/mlfs_out_reg.sv
// ----------------------------------------------------------------------------
// mlfs_out_reg
// Result register: hold one result word until the sink takes it.
// ----------------------------------------------------------------------------
module mlfs_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              res_valid,
	input  mlfs_pkg::result_t res,
	output logic              can_take,
	mlfs_result_if.source     result_out
);
	import mlfs_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign can_take = !valid_s2 || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_take) begin
			valid_s2 <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take) begin
			res_s2 <= res;
		end
	end

	assign result_out.valid        = valid_s2;
	assign result_out.kind         = res_s2.kind;
	assign result_out.error_code   = res_s2.error_code;
	assign result_out.payload_byte = res_s2.payload_byte;
	assign result_out.frame_length = res_s2.frame_length;
	assign result_out.last_byte    = res_s2.last_byte;

endmodule

FILE: sv/marker_length_frame_splitter_unit.sv
// ----------------------------------------------------------------------------
// marker_length_frame_splitter_unit
// Splits a byte stream into marker/length-prefixed frames.
// ----------------------------------------------------------------------------
// The unit takes one byte word per cycle while results are taken, and each
// result passes input register, parse logic and result register in turn.
// A frame is the start marker 0x80, a signed 16-bit length sent low byte
// first, and that many payload bytes. Header bytes give no result. Each
// payload byte comes out with the frame length and a last mark on the final
// byte. A byte other than the marker while hunting gives a bad-marker error
// word at once. The length is checked on the first payload byte: it must be
// at least 3 and at most max_payload_length (negative lengths fail); on
// failure that byte is dropped and a length error word is sent instead.
// After any error the unit hunts for a marker again. The sustained rate is
// one byte per cycle while the sink is ready, set by the state update between
// the two registers; the input side keeps taking bytes while a result
// waits, until both registers are full. Write max_payload_length (reset
// 1024) through cfg_we/cfg_data only while the unit is idle.
// ----------------------------------------------------------------------------
module marker_length_frame_splitter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mlfs_pkg::LenW-1:0] cfg_data,
	mlfs_byte_if.sink                 byte_in,
	mlfs_result_if.source             result_out
);
	import mlfs_pkg::*;

	step_t   step;
	logic    can_take;
	logic    res_valid;
	result_t res;

	// hold the incoming byte word until the result side can move
	mlfs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.can_take (can_take),
		.step     (step)
	);

	// advance the frame state and build the result word
	mlfs_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.step      (step),
		.res_valid (res_valid),
		.res       (res)
	);

	// hold the result word; drop header bytes, which give no result
	mlfs_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (step.fire),
		.res_valid  (res_valid),
		.res        (res),
		.can_take   (can_take),
		.result_out (result_out)
	);

endmodule
